// ----- design/timed_unit_lease_admission_assert.svh -----
// assertion macros for the lease admission block
// used by the modules that carry concurrent checks
`ifndef TIMED_UNIT_LEASE_ADMISSION_ASSERT_SVH
`define TIMED_UNIT_LEASE_ADMISSION_ASSERT_SVH
// implication checked on every clock, off during reset
`define TULA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define TULA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ----- design/tula_pkg.sv -----
// shared types and constants for the lease admission block
// no dependencies
package tula_pkg;
   localparam int JobSlotsDefault = 16;
   localparam logic [7:0] CapacityReset = 8'd8;

   localparam logic       CmdAssign = 1'b0;
   localparam logic       CmdTick   = 1'b1;

   localparam logic [1:0] StatAccepted  = 2'd0;
   localparam logic [1:0] StatNoCap     = 2'd1;
   localparam logic [1:0] StatFull      = 2'd2;
   localparam logic [1:0] StatNotAssign = 2'd3;

   typedef struct packed {
      logic        command;
      logic [31:0] job_id;
      logic [7:0]  units_wanted;
      logic [15:0] run_ticks;
   } req_type;

   typedef struct packed {
      logic [1:0]  assign_status;
      logic        done_valid;
      logic [31:0] done_job;
      logic [7:0]  load_now;
      logic [4:0]  jobs_running;
      logic        last;
   } rsp_type;
endpackage

// ----- design/tula_front.sv -----
// front part: accepts request beats and pushes them into a short queue
// depends on tula_pkg
module tula_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tula_pkg::req_type req_data,
   output logic              q_valid,
   input  logic              q_ready,
   output tula_pkg::req_type q_data
);
   import tula_pkg::*;

   // two-entry queue
   req_type     mem_ff [2];
   logic        wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push, pop;

   assign req_ready = (cnt_ff != 2'd2);
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_data    = mem_ff[rptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;

   always_comb begin
      wptr_in = push ? ~wptr_ff : wptr_ff;
      rptr_in = pop ? ~rptr_ff : rptr_ff;
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end
endmodule

// ----- design/tula_back.sv -----
// back part: job table, admission check and the tick walk
// depends on tula_pkg and the assertion header
`include "timed_unit_lease_admission_assert.svh"
module tula_back #(
   parameter int JOB_SLOTS = tula_pkg::JobSlotsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        capacity,
   input  logic              q_valid,
   output logic              q_ready,
   input  tula_pkg::req_type q_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tula_pkg::rsp_type rsp_data
);
   import tula_pkg::*;
   localparam int IW = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
   localparam int CW = $clog2(JOB_SLOTS + 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_WALK = 4'b0010,
      ST_EMIT = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   // table memories, read one slot per cycle
   logic [31:0] id_mem  [JOB_SLOTS];
   logic [7:0]  un_mem  [JOB_SLOTS];
   logic [15:0] rem_mem [JOB_SLOTS];

   state_type   state_ff, state_in;
   logic [CW-1:0] count_ff, count_in, rd_ff, rd_in, keep_ff, keep_in;
   logic [CW-1:0] nd_ff, nd_in, ep_ff, ep_in;
   logic [7:0]  load_ff, load_in;
   logic        out_v_ff, out_v_in;
   rsp_type     out_ff, out_in;
   // ids of finished jobs
   logic [31:0] done_mem [JOB_SLOTS];
   logic [31:0] done_rd_ff;

   logic [8:0]  sum;
   logic [31:0] rd_id_ff;
   logic [7:0]  rd_un_ff;
   logic [15:0] rd_rem_ff;
   logic        finishing;
   logic        wr_en, dn_en;

   assign finishing = (rd_rem_ff <= 16'd1);
   assign sum = {1'b0, load_ff} + {1'b0, q_data.units_wanted};
   assign q_ready   = (state_ff == ST_IDLE) && !out_v_ff;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   // control
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      rd_in    = rd_ff;
      keep_in  = keep_ff;
      nd_in    = nd_ff;
      ep_in    = ep_ff;
      load_in  = load_ff;
      out_v_in = out_v_ff && !rsp_ready;
      out_in   = out_ff;
      wr_en    = 1'b0;
      dn_en    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && q_ready) begin
               if (q_data.command == CmdAssign) begin
                  out_in = '0;
                  out_in.last = 1'b1;
                  if (sum > {1'b0, capacity}) begin
                     out_in.assign_status = StatNoCap;
                  end else if (count_ff >= CW'(JOB_SLOTS)) begin
                     out_in.assign_status = StatFull;
                  end else begin
                     out_in.assign_status = StatAccepted;
                     count_in = count_ff + 1'b1;
                     load_in  = sum[7:0];
                  end
                  out_in.load_now     = load_in;
                  out_in.jobs_running = 5'(count_in);
                  out_v_in = 1'b1;
               end else begin
                  rd_in = '0; keep_in = '0; nd_in = '0;
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (rd_ff == count_ff) begin
               count_in = keep_ff;
               ep_in    = '0;
               state_in = ST_EMIT;
            end else begin
               rd_in = rd_ff + 1'b1;
               if (finishing) begin
                  load_in = load_ff - rd_un_ff;
                  dn_en   = 1'b1;
                  nd_in   = nd_ff + 1'b1;
               end else begin
                  wr_en   = 1'b1;
                  keep_in = keep_ff + 1'b1;
               end
            end
         end
         ST_EMIT: begin
            // wait for the registered read of finished ids
            if (!out_v_ff || rsp_ready) state_in = ST_OUT;
            if (nd_ff == '0 && (!out_v_ff || rsp_ready)) begin
               out_in = '0;
               out_in.assign_status = StatNotAssign;
               out_in.load_now = load_ff;
               out_in.jobs_running = 5'(count_ff);
               out_in.last = 1'b1;
               out_v_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (!out_v_ff || rsp_ready) begin
               out_in.assign_status = StatNotAssign;
               out_in.done_valid    = 1'b1;
               out_in.done_job      = done_rd_ff;
               out_in.load_now      = load_ff;
               out_in.jobs_running  = 5'(count_ff);
               out_in.last          = (ep_ff + 1'b1 == nd_ff);
               out_v_in = 1'b1;
               ep_in    = ep_ff + 1'b1;
               state_in = (ep_ff + 1'b1 == nd_ff) ? ST_IDLE : ST_EMIT;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // registered table read, address follows the walk pointer
   // the slot being compacted into always sits below the slot being read
   always_ff @(posedge clock) begin
      rd_id_ff  <= id_mem[rd_in[IW-1:0]];
      rd_un_ff  <= un_mem[rd_in[IW-1:0]];
      rd_rem_ff <= rem_mem[rd_in[IW-1:0]];
   end

   // table and finished-id writes
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && q_valid && q_ready && q_data.command == CmdAssign
          && sum <= {1'b0, capacity} && count_ff < CW'(JOB_SLOTS)) begin
         id_mem[count_ff[IW-1:0]]  <= q_data.job_id;
         un_mem[count_ff[IW-1:0]]  <= q_data.units_wanted;
         rem_mem[count_ff[IW-1:0]] <= q_data.run_ticks;
      end else if (wr_en) begin
         id_mem[keep_ff[IW-1:0]]  <= rd_id_ff;
         un_mem[keep_ff[IW-1:0]]  <= rd_un_ff;
         rem_mem[keep_ff[IW-1:0]] <= rd_rem_ff - 16'd1;
      end
      if (dn_en) begin
         done_mem[nd_ff[IW-1:0]] <= rd_id_ff;
      end
      done_rd_ff <= done_mem[ep_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rd_ff    <= '0;
         keep_ff  <= '0;
         nd_ff    <= '0;
         ep_ff    <= '0;
         load_ff  <= '0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rd_ff    <= rd_in;
         keep_ff  <= keep_in;
         nd_ff    <= nd_in;
         ep_ff    <= ep_in;
         load_ff  <= load_in;
         out_v_ff <= out_v_in;
      end
   end

   `TULA_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(JOB_SLOTS))
   `TULA_ASSERT_IMP(a_keep_le_rd, clock, reset, state_ff == ST_WALK, keep_ff <= rd_ff)
   `TULA_ASSERT_NXT(a_stall_hold, clock, reset, out_v_ff && !rsp_ready, $stable(out_ff))
   `TULA_ASSERT_IMP(a_no_take_busy, clock, reset, state_ff != ST_IDLE, !q_ready)
endmodule

// ----- design/timed_unit_lease_admission.sv -----
// top level of the lease admission block
// depends on tula_pkg, tula_front and tula_back
// An assign beat passes the queue register, then the admission check into the output
// register, when the back part is idle with its output register free. A tick walks the
// job table one slot per cycle, then sends one result per finished job, each after a
// wait state for the registered read of the finished-id store, or a single result when
// no job finished. A two-beat queue in front lets requests be taken while the back part
// works or waits on rsp_ready.
module timed_unit_lease_admission #(
   parameter int JOB_SLOTS = tula_pkg::JobSlotsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tula_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tula_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_data
);
   import tula_pkg::*;

   logic [7:0] cap_ff;
   logic       q_valid, q_ready;
   req_type    q_data;

   // capacity register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CapacityReset;
      end else if (csr_valid) begin
         cap_ff <= csr_data;
      end
   end

   tula_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .q_valid, .q_ready, .q_data
   );

   tula_back #(.JOB_SLOTS(JOB_SLOTS)) u_back (
      .clock, .reset, .capacity(cap_ff), .q_valid, .q_ready, .q_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );
endmodule

// ----- tb/timed_unit_lease_admission_test.sv -----
// testbench for the lease admission block: directed and random assign/tick beats
// with a scoreboard fed by an in-bench prediction; depends on tula_pkg and the rtl
`timescale 1ns / 1ps
module timed_unit_lease_admission_test;
   import tula_pkg::*;

   localparam int Slots = 16;
   localparam int IdleLimit = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [7:0] csr_data = '0;

   timed_unit_lease_admission u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predicted state of the job table
   logic [31:0] lease_id [Slots];
   logic [7:0]  lease_units [Slots];
   logic [15:0] lease_left [Slots];
   int          lease_count;
   logic [7:0]  load_pred;
   logic [7:0]  capacity_pred;

   rsp_type expected_rsps[$];
   int errors = 0;
   int beats_sent = 0;
   int rsps_seen = 0;
   int done_seen = 0;
   bit idle_off = 1'b0;
   int quiet_cycles = 0;

   // work out the results one request causes
   task automatic predict_lease(input req_type r);
      rsp_type o;
      logic [31:0] fin [$];
      int keep;
      o = '0;
      if (r.command == CmdAssign) begin
         if (9'(load_pred) + 9'(r.units_wanted) > 9'(capacity_pred))
            o.assign_status = StatNoCap;
         else if (lease_count >= Slots)
            o.assign_status = StatFull;
         else begin
            lease_id[lease_count] = r.job_id;
            lease_units[lease_count] = r.units_wanted;
            lease_left[lease_count] = r.run_ticks;
            lease_count++;
            load_pred = load_pred + r.units_wanted;
            o.assign_status = StatAccepted;
         end
         o.load_now = load_pred;
         o.jobs_running = 5'(lease_count);
         o.last = 1'b1;
         expected_rsps = {expected_rsps, o};
      end else begin
         keep = 0;
         for (int i = 0; i < lease_count; i++) begin
            if (lease_left[i] <= 16'd1) begin
               load_pred = load_pred - lease_units[i];
               fin = {fin, lease_id[i]};
            end else begin
               lease_id[keep] = lease_id[i];
               lease_units[keep] = lease_units[i];
               lease_left[keep] = lease_left[i] - 16'd1;
               keep++;
            end
         end
         lease_count = keep;
         o.assign_status = StatNotAssign;
         o.load_now = load_pred;
         o.jobs_running = 5'(lease_count);
         if (fin.size() == 0) begin
            o.last = 1'b1;
            expected_rsps = {expected_rsps, o};
         end else
            foreach (fin[k]) begin
               o.done_valid = 1'b1;
               o.done_job = fin[k];
               o.last = (k == fin.size() - 1);
               expected_rsps = {expected_rsps, o};
            end
      end
   endtask

   // send one request beat, sometimes after a random gap; valid stays up between beats with no gap
   task automatic send_beat(input req_type r);
      if (!idle_off && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < 30) @(posedge clock);
      end
      predict_lease(r);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
   endtask

   task automatic send_assign(input logic [31:0] id, input logic [7:0] u,
                              input logic [15:0] t);
      req_type r;
      r = '0;
      r.command = CmdAssign;
      r.job_id = id;
      r.units_wanted = u;
      r.run_ticks = t;
      send_beat(r);
   endtask

   task automatic send_tick();
      req_type r;
      r = '0;
      r.job_id = $urandom;
      r.units_wanted = 8'($urandom);
      r.run_ticks = 16'($urandom);
      r.command = CmdTick;
      send_beat(r);
   endtask

   task automatic drain_wait();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // capacity write, only while idle
   task automatic write_capacity(input logic [7:0] v);
      drain_wait();
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      capacity_pred = v;
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsps_seen++;
         if (rsp_data.done_valid) done_seen++;
         if (expected_rsps.size() == 0) begin
            $error("result with nothing expected: %h", rsp_data);
            errors++;
         end else begin
            rsp_type e;
            e = expected_rsps.pop_front();
            if (rsp_data.assign_status !== e.assign_status) begin
               $error("assign_status exp %0d got %0d", e.assign_status,
                      rsp_data.assign_status);
               errors++;
            end
            if (rsp_data.done_valid !== e.done_valid) begin
               $error("done_valid exp %0d got %0d", e.done_valid, rsp_data.done_valid);
               errors++;
            end
            if (rsp_data.done_job !== e.done_job) begin
               $error("done_job exp %h got %h", e.done_job, rsp_data.done_job);
               errors++;
            end
            if (rsp_data.load_now !== e.load_now) begin
               $error("load_now exp %0d got %0d", e.load_now, rsp_data.load_now);
               errors++;
            end
            if (rsp_data.jobs_running !== e.jobs_running) begin
               $error("jobs_running exp %0d got %0d", e.jobs_running,
                      rsp_data.jobs_running);
               errors++;
            end
            if (rsp_data.last !== e.last) begin
               $error("last exp %0d got %0d", e.last, rsp_data.last);
               errors++;
            end
         end
      end
   end

   // receiver stalls
   always @(posedge clock)
      rsp_ready <= idle_off ? 1'b1 : ($urandom_range(99) >= 30);

   // watchdog on cycles with no beat accepted
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)
          || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > IdleLimit) begin
         $display("FAIL timed_unit_lease_admission");
         $finish;
      end
   end

   // edges of the fields, table full, no-capacity precedence, zero ticks
   task automatic test_directed();
      send_tick();
      send_assign(32'hFFFF_FFFF, 8'd0, 16'd0);
      send_assign(32'h0000_0000, 8'd8, 16'd1);
      send_assign(32'h1, 8'd1, 16'd2);
      send_tick();
      send_tick();
      send_tick();
      write_capacity(8'd255);
      for (int i = 0; i < Slots; i++) send_assign(32'h100 + i, 8'd1, 16'(i % 3 + 1));
      send_assign(32'hABCD, 8'd1, 16'hFFFF);
      send_assign(32'hABCE, 8'd255, 16'd5);
      send_tick();
      send_tick();
      send_tick();
      send_tick();
      write_capacity(8'd0);
      send_assign(32'h5, 8'd0, 16'hFFFF);
      send_assign(32'h6, 8'd1, 16'd1);
      send_tick();
      send_tick();
   endtask

   // capacity lowered under the running load
   task automatic test_lowered_capacity();
      write_capacity(8'd200);
      send_assign(32'h77, 8'd150, 16'd4);
      write_capacity(8'd10);
      send_assign(32'h78, 8'd0, 16'd1);
      repeat (4) send_tick();
   endtask

   // random well-formed mixes across several capacities
   task automatic test_random(input int count, input logic [7:0] cap);
      write_capacity(cap);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 35) send_tick();
         else if ($urandom_range(9) == 0)
            send_assign($urandom, 8'($urandom), 16'($urandom));
         else
            send_assign($urandom, 8'($urandom_range(cap / 4 + 1)), 16'($urandom_range(6)));
         if (n == count / 2 && $urandom_range(1)) drain_wait();
      end
   endtask

   initial begin
      lease_count = 0;
      load_pred = '0;
      capacity_pred = CapacityReset;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_lowered_capacity();
      test_random(100, 8'd8);
      test_random(100, 8'd255);
      drain_wait();
      idle_off = 1'b1;
      test_random(80, 8'd60);
      idle_off = 1'b0;
      test_random(120, 8'd128);
      repeat (20) send_tick();
      drain_wait();
      $display("covered %0d request beats, %0d results, %0d finished jobs",
               beats_sent, rsps_seen, done_seen);
      $display("capacities 0, 8, 10, 60, 128, 200 and 255 with a full table");
      if (errors == 0 && expected_rsps.size() == 0)
         $display("PASS timed_unit_lease_admission");
      else
         $display("FAIL timed_unit_lease_admission");
      $finish;
   end
endmodule
